FILE: rtl/core/amf_pkg.sv
package amf_pkg;

    // address width of one list entry
    localparam int unsigned MAC_W = 48;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_CHECK     = 2'd0,
        MODE_ADD_ALLOW = 2'd1,
        MODE_ADD_DENY  = 2'd2,
        MODE_CLEAR     = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [7:0] CFG_ADDR_TYPE_MASK = 8'd0;
    localparam logic [7:0] CFG_MAX_DATA_LEN   = 8'd1;

    // register reset values
    localparam logic [7:0] ADDR_TYPE_MASK_RST = 8'd0;
    localparam logic [7:0] MAX_DATA_LEN_RST   = 8'd229;

    // control sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [MAC_W-1:0] mac;
    } scan_t;

    // entry write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [MAC_W-1:0] mac;
    } list_wr_t;

endpackage

FILE: rtl/core/amf_cell.sv
module amf_cell
    import amf_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  list_wr_t         wr,
    input  logic [CNT_W-1:0] count,
    input  scan_t            scan_in,
    output scan_t            scan_out
);

    logic [MAC_W-1:0] entry_reg;
    logic             valid_reg;
    logic             hit_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             used;
    logic             match;

    // this cell holds a live entry when its slot lies below the fill count
    assign used  = CNT_W'(INDEX) < count;
    assign match = used && (entry_reg == scan_in.mac);

    // entry storage: written when the add targets this slot
    always_ff @(posedge aclk) begin
        if (wr.en && (count == CNT_W'(INDEX))) begin
            entry_reg <= wr.mac;
        end
    end

    // token stage toward the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= scan_in.hit | match;
        mac_reg <= scan_in.mac;
    end

    assign scan_out.valid = valid_reg;
    assign scan_out.hit   = hit_reg;
    assign scan_out.mac   = mac_reg;

endmodule

FILE: rtl/core/amf_cell_row.sv
module amf_cell_row
    import amf_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 16,
    parameter int unsigned CNT_W      = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  list_wr_t         wr,
    input  logic [CNT_W-1:0] count,
    input  scan_t            launch,
    output scan_t            tail
);

    scan_t links [0:LIST_DEPTH];

    assign links[0] = launch;

    // one cell per list slot, token walks from slot 0 upward
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        amf_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr       (wr),
            .count    (count),
            .scan_in  (links[i]),
            .scan_out (links[i+1])
        );
    end

    assign tail = links[LIST_DEPTH];

endmodule

FILE: rtl/core/adv_report_mac_filter.sv
// Advertising report admission filter with an address allow/deny list.
// Input items arrive on the s_ stream: tuser carries the request kind
// (check report, add to allow list, add to deny list, clear list) and
// tdata the address and report fields. Every item gives one result item
// on the m_ stream with the accept flag and the list count; a clear reports LIST_DEPTH.
// Registers (address type mask, max data length) are written through the
// cfg_ channel, which is always ready; write them only while idle.
// Results: a command's result is loaded into the output register as
// the command is taken. A check walks a token through the row of
// LIST_DEPTH cells, one cell per cycle, and its result is loaded into
// the output register once the token leaves the last cell.
// Throughput: one item at a time; the next item is taken once the
// sequencer is idle and the output register is empty or being read,
// so commands run at one per cycle while m_tready stays high.
// Reset empties the list (count zero), selects allow list mode, loads
// the register defaults and drops any pending result. When m_tready is
// low the result holds in the output register and s_tready stays low.
module adv_report_mac_filter
    import amf_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // mac[47:0], addr_type[55:48], data_len[63:56], rssi[71:64]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // accept[0], list_count[5:1], zero[7:6]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [4:0] DEPTH_OUT = 5'(LIST_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             deny_reg, deny_next;
    logic [7:0]       mask_reg;
    logic [7:0]       max_len_reg;
    logic             pass_reg, pass_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_accept_reg, m_accept_next;
    logic [4:0]       m_count_reg, m_count_next;

    mode_t            mode;
    logic [MAC_W-1:0] mac;
    logic [7:0]       addr_type;
    logic [7:0]       data_len;
    logic [7:0]       rssi;
    logic             take;
    logic             fields_ok;
    logic             list_ok;
    logic [CNT_W+4:0] count_wide;
    list_wr_t         wr;
    scan_t            launch;
    scan_t            tail;

    // unpack the request
    assign mode      = mode_t'(s_tuser);
    assign mac       = s_tdata[47:0];
    assign addr_type = s_tdata[55:48];
    assign data_len  = s_tdata[63:56];
    assign rssi      = s_tdata[71:64];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // report field checks, done at intake
    assign fields_ok = (data_len != 8'd0) && (data_len <= max_len_reg) &&
                       ((addr_type & mask_reg) == 8'd0) && (rssi != 8'd0);

    // list verdict once the token leaves the last cell
    assign list_ok    = (count_reg == '0) || (deny_reg ? !tail.hit : tail.hit);
    assign count_wide = {5'd0, count_reg};

    // cell row drive
    assign launch.valid = take && (mode == MODE_CHECK);
    assign launch.hit   = 1'b0;
    assign launch.mac   = mac;

    assign wr.en  = take && ((mode == MODE_ADD_ALLOW) || (mode == MODE_ADD_DENY)) &&
                    (count_reg < DEPTH_CNT);
    assign wr.mac = mac;

    amf_cell_row #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .count   (count_reg),
        .launch  (launch),
        .tail    (tail)
    );

    // sequencer, list state and result register next values
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        deny_next     = deny_reg;
        pass_next     = pass_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_accept_next = m_accept_reg;
        m_count_next  = m_count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    unique case (mode)
                        MODE_CHECK: begin
                            pass_next  = fields_ok;
                            state_next = ST_SCAN;
                        end
                        MODE_ADD_ALLOW, MODE_ADD_DENY: begin
                            deny_next = (mode == MODE_ADD_DENY);
                            if (wr.en) begin
                                count_next = count_reg + 1'b1;
                            end
                            m_valid_next  = 1'b1;
                            m_accept_next = 1'b0;
                            m_count_next  = count_next == '0 ? 5'd0 :
                                            5'({5'd0, count_next});
                        end
                        MODE_CLEAR: begin
                            count_next    = '0;
                            m_valid_next  = 1'b1;
                            m_accept_next = 1'b0;
                            m_count_next  = DEPTH_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    m_valid_next  = 1'b1;
                    m_accept_next = pass_reg && list_ok;
                    m_count_next  = count_wide[4:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            deny_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            deny_reg    <= deny_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pass_reg     <= pass_next;
        m_accept_reg <= m_accept_next;
        m_count_reg  <= m_count_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= ADDR_TYPE_MASK_RST;
            max_len_reg <= MAX_DATA_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ADDR_TYPE_MASK) begin
                mask_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_DATA_LEN) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_accept_reg};

    // a token leaves the row only while a check is in flight
    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == ST_SCAN))
        else $error("token left the cell row outside a check");

    // the fill count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("list count above capacity");

    // a command gives its result in the next cycle
    a_cmd_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (s_tuser != MODE_CHECK)) |=> m_valid_reg)
        else $error("command result missing");

    // a check starts a scan and holds off further items
    a_check_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (s_tuser == MODE_CHECK)) |=> ((state_reg == ST_SCAN) && !s_tready))
        else $error("check did not start a scan");

endmodule
